// ===== hdl/hrrip_pkg.sv =====
package hrrip_pkg;
    localparam int SETS = 2048;
    localparam int WAYS = 16;
    localparam int LEADER_COUNT = 32;
    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = 4;
    localparam int RRPV_W = 2 * WAYS;
    localparam int SIG_W = 4 * WAYS;
    // stride 8, score 2, last block 9
    localparam int STR_W = 19;
    localparam int SEL_W = 10;
    localparam logic [SEL_W-1:0] SEL_RESET = 10'd512;
    localparam logic [SEL_W-1:0] SEL_MAX = 10'd1023;
    localparam logic [3:0] CNT_MAX = 4'd15;
    localparam logic [3:0] CNT_HIGH = 4'd12;
    localparam logic [3:0] CNT_MID = 4'd8;
    localparam logic FUNC_VICTIM = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic       func;
        logic [10:0] set_index;
        logic [3:0] way;
        logic [63:0] paddr;
        logic [63:0] pc;
        logic       hit;
    } req_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic [1:0] inserted_rrpv;
        logic       streaming;
    } rsp_t;

    function automatic logic [3:0] pc_hash(input logic [63:0] pc);
        logic [63:0] h;
        h = pc ^ (pc >> 11) ^ (pc >> 17);
        return h[3:0];
    endfunction

    function automatic logic [3:0] counter_slot(input logic [3:0] sig);
        return sig ^ {2'b00, sig[3:2]};
    endfunction
endpackage

// ===== hdl/hrrip_if.sv =====
interface hrrip_req_if;
    import hrrip_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hrrip_rsp_if;
    import hrrip_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/hrrip_ram.sv =====
module hrrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/hrrip_update.sv =====
module hrrip_update import hrrip_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  req_t              req,
    input  logic [RRPV_W-1:0] rrpv_in,
    input  logic [SIG_W-1:0]  sig_in,
    input  logic [STR_W-1:0]  str_in,
    output logic [RRPV_W-1:0] rrpv_out,
    output logic [SIG_W-1:0]  sig_out,
    output logic [STR_W-1:0]  str_out,
    output rsp_t              rsp
);
    logic [3:0] cnt_reg [16];
    logic [3:0] cnt_next [16];
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic [4:0] lph_reg, lph_next, fph_reg, fph_next;

    logic [SET_W-1:0] s;
    logic [3:0] w, sig, slot, old_sig, old_slot;
    logic [7:0] blk, stride, ostride, ldiff;
    logic [1:0] score, oscore, ins, mx, k;
    logic [8:0] olast;
    logic streaming, lipl, bipl;
    logic [2:0] t;
    logic [1:0] rv;
    logic [3:0] vic;

    always_comb
    begin
        s = req.set_index[SET_W-1:0];
        w = req.way;
        sig = pc_hash(req.pc);
        slot = counter_slot(sig);
        blk = req.paddr[13:6];
        ostride = str_in[7:0];
        oscore = str_in[9:8];
        olast = str_in[18:10];
        ldiff = blk - olast[7:0];
        stride = olast[8] ? ldiff : 8'd0;
        if (stride != 8'd0 && stride == ostride)
        begin
            score = (oscore == 2'd3) ? oscore : oscore + 2'd1;
        end
        else
        begin
            score = 2'd0;
        end
        streaming = score[1];
        // a victim request leaves the stream detector untouched
        str_out = (req.func == FUNC_UPDATE) ? {req.paddr != 64'd0, blk, score, stride}
                                            : str_in;
        lipl = s < SET_W'(LEADER_COUNT / 2);
        bipl = !lipl && s < SET_W'(LEADER_COUNT);
        for (int i = 0; i < 16; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        sel_next = sel_reg;
        lph_next = lph_reg;
        fph_next = fph_reg;
        rrpv_out = rrpv_in;
        sig_out = sig_in;
        old_sig = sig_in[4*w +: 4];
        old_slot = counter_slot(old_sig);
        ins = 2'd0;
        // victim aging
        mx = 2'd0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (rrpv_in[2*i +: 2] > mx)
            begin
                mx = rrpv_in[2*i +: 2];
            end
        end
        k = 2'd3 - mx;
        vic = 4'd0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            t = {1'b0, rrpv_in[2*i +: 2]} + {1'b0, k};
            rv = t[2] ? 2'd3 : t[1:0];
            if (req.func == FUNC_VICTIM)
            begin
                rrpv_out[2*i +: 2] = rv;
            end
            if (rv == 2'd3)
            begin
                vic = 4'(i);
            end
        end
        if (req.func == FUNC_UPDATE)
        begin
            vic = 4'd0;
            if (req.hit)
            begin
                rrpv_out[2*w +: 2] = 2'd0;
                if (cnt_reg[slot] != CNT_MAX)
                begin
                    cnt_next[slot] = cnt_reg[slot] + 4'd1;
                end
            end
            else
            begin
                if (lipl)
                begin
                    ins = 2'd3;
                end
                else if (bipl)
                begin
                    ins = (lph_reg == 5'd0) ? 2'd0 : 2'd3;
                    lph_next = lph_reg + 5'd1;
                end
                else if (sel_reg >= SEL_RESET)
                begin
                    ins = (fph_reg == 5'd0) ? 2'd0 : 2'd3;
                    fph_next = fph_reg + 5'd1;
                end
                else
                begin
                    ins = 2'd3;
                end
                if (streaming)
                begin
                    ins = 2'd3;
                end
                else if (cnt_reg[slot] >= CNT_HIGH)
                begin
                    ins = 2'd0;
                end
                else if (cnt_reg[slot] >= CNT_MID && ins > 2'd1)
                begin
                    ins = 2'd1;
                end
                rrpv_out[2*w +: 2] = ins;
                if (cnt_reg[old_slot] != 4'd0)
                begin
                    cnt_next[old_slot] = cnt_reg[old_slot] - 4'd1;
                end
                sig_out[4*w +: 4] = sig;
                if (lipl && sel_reg != SEL_MAX)
                begin
                    sel_next = sel_reg + 10'd1;
                end
                else if (bipl && sel_reg != 10'd0)
                begin
                    sel_next = sel_reg - 10'd1;
                end
            end
        end
        rsp.victim_way = vic;
        rsp.inserted_rrpv = (req.func == FUNC_UPDATE) ? ins : 2'd0;
        rsp.streaming = (req.func == FUNC_UPDATE) ? streaming : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                cnt_reg[i] <= 4'd2;
            end
            sel_reg <= SEL_RESET;
            lph_reg <= 5'd0;
            fph_reg <= 5'd0;
        end
        else if (start)
        begin
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
            lph_reg <= lph_next;
            fph_reg <= fph_next;
        end
    end
endmodule

// ===== hdl/hybrid_rrip_cache_replacement_unit.sv =====
// The set is read from memory as the request is accepted; the WORK state then
// updates it and writes it back, and the registered result is offered in SEND.
// The input waits until the result has been taken, so no new request is
// accepted meanwhile; a stalled result stalls the input.
// After reset the unit sweeps all sets to write their reset values before it
// accepts a request; counters and selector reset at once.
module hybrid_rrip_cache_replacement_unit import hrrip_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    hrrip_req_if.sink   req,
    hrrip_rsp_if.source rsp
);
    typedef enum logic [1:0] {CLEAR, IDLE, WORK, SEND} state_t;
    state_t state_reg;
    logic [SET_W-1:0] clr_reg;
    req_t req_reg;
    rsp_t rsp_reg, rsp_c;
    logic [RRPV_W-1:0] rrpv_rd, rrpv_wr;
    logic [SIG_W-1:0] sig_rd, sig_wr;
    logic [STR_W-1:0] str_rd, str_wr;
    logic we, start, accept;
    logic [SET_W-1:0] waddr;

    assign req.ready = (state_reg == IDLE);
    assign accept = req.valid && req.ready;
    assign start = (state_reg == WORK);
    assign we = start || state_reg == CLEAR;
    assign waddr = (state_reg == CLEAR) ? clr_reg : req_reg.set_index[SET_W-1:0];
    assign rsp.valid = (state_reg == SEND);
    assign rsp.payload = rsp_reg;

    hrrip_ram #(.WIDTH(RRPV_W), .DEPTH(SETS)) u_rrpv (
        .clk(clk), .we(we), .waddr(waddr),
        .wdata(state_reg == CLEAR ? {WAYS{2'd2}} : rrpv_wr),
        .raddr(req.payload.set_index[SET_W-1:0]), .rdata(rrpv_rd));
    hrrip_ram #(.WIDTH(SIG_W), .DEPTH(SETS)) u_sig (
        .clk(clk), .we(we), .waddr(waddr),
        .wdata(state_reg == CLEAR ? {SIG_W{1'b0}} : sig_wr),
        .raddr(req.payload.set_index[SET_W-1:0]), .rdata(sig_rd));
    hrrip_ram #(.WIDTH(STR_W), .DEPTH(SETS)) u_str (
        .clk(clk), .we(we), .waddr(waddr),
        .wdata(state_reg == CLEAR ? {STR_W{1'b0}} : str_wr),
        .raddr(req.payload.set_index[SET_W-1:0]), .rdata(str_rd));

    hrrip_update u_upd (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req_reg),
        .rrpv_in(rrpv_rd), .sig_in(sig_rd), .str_in(str_rd),
        .rrpv_out(rrpv_wr), .sig_out(sig_wr), .str_out(str_wr), .rsp(rsp_c));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLEAR;
            clr_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SET_W'(SETS - 1))
                    begin
                        state_reg <= IDLE;
                    end
                end
                IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= WORK;
                    end
                end
                WORK:
                begin
                    state_reg <= SEND;
                end
                SEND:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req.payload;
        end
        if (start)
        begin
            rsp_reg <= rsp_c;
        end
    end
endmodule
